// File: design/r2e_pkg.sv
`default_nettype none
package r2e_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int DATA_BITS         = 16;
	localparam int FIFO_DEPTH        = 4;

	// operand width of the atan2 inputs, Q22 values of the Q2.14 elements
	localparam int OW         = 26;
	localparam int REM_W      = 29;
	localparam int SQ_STEPS   = 23;
	localparam int VW         = 46;
	localparam int ONE_Q14    = 16384;
	localparam int ATAN_STEPS = 24;

	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam longint ATAN_Q30 [ATAN_STEPS] = '{
		64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
		64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
		64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
		64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
		64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
		64'sd1024,      64'sd512,       64'sd256,       64'sd128
	};

	// one classified matrix on its way from front to back
	typedef struct packed {
		logic                 gen;
		logic                 neg;
		logic signed [OW-1:0] ax_y;
		logic signed [OW-1:0] ax_x;
		logic signed [OW-1:0] ay_y;
		logic signed [OW-1:0] az_y;
		logic signed [OW-1:0] az_x;
		logic [REM_W-1:0]     rem;
	} item_t;

	// q30 angle rounded half up to db fraction bits
	function automatic longint scale_q30(input longint t, input int db);
		longint r;
		if (db >= 30) begin
			r = t <<< (db - 30);
		end else begin
			r = (t + (longint'(1) <<< (29 - db))) >>> (30 - db);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/r2e_front.sv
`default_nettype none
module r2e_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] right_x,
	input  wire logic signed [15:0] right_y,
	input  wire logic signed [15:0] right_z,
	input  wire logic signed [15:0] up_z,
	input  wire logic signed [15:0] front_x,
	input  wire logic signed [15:0] front_y,
	input  wire logic signed [15:0] front_z,
	input  wire logic               fifo_full,
	output logic                    fifo_push,
	output r2e_pkg::item_t          fifo_item
);
	localparam int OW = r2e_pkg::OW;
	localparam logic signed [15:0] ONE = 16'(r2e_pkg::ONE_Q14);

	logic vld_s1;
	logic en;
	logic signed [15:0] rx_s1, ry_s1, rz_s1, uz_s1, fx_s1, fy_s1, fz_s1;
	logic signed [31:0] sq;
	logic [31:0] remw;
	logic gen;

	assign en   = !vld_s1 || !fifo_full;
	assign full = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (en && push) begin
			rx_s1 <= right_x;
			ry_s1 <= right_y;
			rz_s1 <= right_z;
			uz_s1 <= up_z;
			fx_s1 <= front_x;
			fy_s1 <= front_y;
			fz_s1 <= front_z;
		end
	end

	function automatic logic signed [OW-1:0] q22(input logic signed [15:0] v);
		return OW'(v) <<< 8;
	endfunction

	assign sq   = rz_s1 * rz_s1;
	assign remw = (32'd1 << 28) - 32'(sq);
	assign gen  = (rz_s1 > -ONE) && (rz_s1 < ONE);

	always_comb begin
		fifo_item.gen  = gen;
		fifo_item.neg  = rz_s1[15];
		fifo_item.ax_y = gen ? -q22(fz_s1) : q22(fx_s1);
		fifo_item.ax_x = gen ? q22(uz_s1) : q22(fy_s1);
		fifo_item.ay_y = q22(rz_s1);
		fifo_item.az_y = -q22(ry_s1);
		fifo_item.az_x = q22(rx_s1);
		fifo_item.rem  = remw[r2e_pkg::REM_W-1:0];
	end

	assign fifo_push = vld_s1 && !fifo_full;

endmodule
`default_nettype wire

// File: design/r2e_fifo.sv
`default_nettype none
module r2e_fifo #(
	parameter int DEPTH = r2e_pkg::FIFO_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire r2e_pkg::item_t  din,
	output logic                 full,
	input  wire logic            pop,
	output r2e_pkg::item_t       dout,
	output logic                 empty
);
	// depth is a power of two
	localparam int AW = $clog2(DEPTH);

	r2e_pkg::item_t mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign dout  = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q[AW-1:0]] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && !empty) begin
				rp_q <= rp_q + 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= (AW+1)'(DEPTH))
		else $error("fifo fill beyond depth");

endmodule
`default_nettype wire

// File: design/r2e_cordic.sv
`default_nettype none
module r2e_cordic #(
	parameter int ITER = r2e_pkg::CORDIC_ITERATIONS,
	parameter int DB   = r2e_pkg::DATA_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic signed [r2e_pkg::OW-1:0] in_y,
	input  wire logic signed [r2e_pkg::OW-1:0] in_x,
	output logic signed [DB+3:0]              z,
	output logic                              zero
);
	localparam int ZW = DB + 4;
	localparam int CW = r2e_pkg::OW + 1;
	localparam logic signed [ZW-1:0] PI_Z = ZW'(r2e_pkg::scale_q30(r2e_pkg::PI_Q30, DB));

	logic signed [CW-1:0] x_s [ITER+1];
	logic signed [CW-1:0] y_s [ITER+1];
	logic signed [ZW-1:0] z_s [ITER+1];
	logic                 zero_s [ITER+1];

	// fold the left half plane over by pi
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			if (in_x < 0) begin
				z_s[0] <= (in_y >= 0) ? PI_Z : -PI_Z;
				x_s[0] <= -CW'(in_x);
				y_s[0] <= -CW'(in_y);
			end else begin
				z_s[0] <= '0;
				x_s[0] <= CW'(in_x);
				y_s[0] <= CW'(in_y);
			end
		end
	end

	for (genvar i = 0; i < ITER; i++) begin : g_step
		localparam logic signed [ZW-1:0] STEP =
			ZW'(r2e_pkg::scale_q30(r2e_pkg::ATAN_Q30[i], DB));
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + STEP;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - STEP;
				end
			end
		end
	end

	assign z    = z_s[ITER];
	assign zero = zero_s[ITER];

endmodule
`default_nettype wire

// File: design/r2e_back.sv
`default_nettype none
module r2e_back #(
	parameter int ITER = r2e_pkg::CORDIC_ITERATIONS,
	parameter int DB   = r2e_pkg::DATA_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_empty,
	input  wire r2e_pkg::item_t     in_item,
	output logic                    in_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [15:0]      angle_x,
	output logic signed [15:0]      angle_y,
	output logic signed [15:0]      angle_z,
	output logic                    unique_res
);
	localparam int ZW  = DB + 4;
	localparam int SQ  = r2e_pkg::SQ_STEPS;
	localparam int VW  = r2e_pkg::VW;
	localparam int OW  = r2e_pkg::OW;
	localparam int L   = SQ + ITER + 3;
	localparam int SH  = DB - 13;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam int SHM1 = (SH > 1) ? SH - 1 : 0;
	localparam logic signed [ZW+1:0] RHALF = (SH > 0) ? ((ZW+2)'(1) << SHM1) : '0;
	localparam logic signed [ZW-1:0] HALF_Z =
		ZW'(r2e_pkg::scale_q30(r2e_pkg::HALF_PI_Q30, DB));

	logic en;
	logic vld_s [L];
	logic [VW-1:0] sqv_s [SQ+1];
	logic [VW-1:0] sqr_s [SQ+1];
	r2e_pkg::item_t sqi_s [SQ+1];
	logic gen_s [ITER+1];
	logic neg_s [ITER+1];
	logic signed [ZW-1:0] cz_x, cz_y, cz_z;
	logic zr_x, zr_y, zr_z;
	logic signed [OW-1:0] c_root;
	logic signed [ZW-1:0] ax, ay, az;
	logic signed [15:0] ang_x_q, ang_y_q, ang_z_q;
	logic uniq_q;

	// whole back end advances together unless a result is held
	assign en     = !vld_s[L-1] || pop;
	assign in_pop = en && !in_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < L; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= !in_empty;
			for (int j = 1; j < L; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	// integer square root, one result bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			sqv_s[0] <= VW'({in_item.rem, 16'b0});
			sqr_s[0] <= '0;
			sqi_s[0] <= in_item;
		end
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [VW-1:0] BIT = VW'(1) << (2 * (SQ - 1 - k));
		logic [VW-1:0] trial;
		assign trial = sqr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				sqi_s[k+1] <= sqi_s[k];
				if (sqv_s[k] >= trial) begin
					sqv_s[k+1] <= sqv_s[k] - trial;
					sqr_s[k+1] <= (sqr_s[k] >> 1) + BIT;
				end else begin
					sqv_s[k+1] <= sqv_s[k];
					sqr_s[k+1] <= sqr_s[k] >> 1;
				end
			end
		end
	end

	assign c_root = $signed(sqr_s[SQ][OW-1:0]);

	r2e_cordic #(.ITER(ITER), .DB(DB)) u_cx (
		.clk(clk), .en(en), .in_y(sqi_s[SQ].ax_y), .in_x(sqi_s[SQ].ax_x),
		.z(cz_x), .zero(zr_x)
	);
	r2e_cordic #(.ITER(ITER), .DB(DB)) u_cy (
		.clk(clk), .en(en), .in_y(sqi_s[SQ].ay_y), .in_x(c_root),
		.z(cz_y), .zero(zr_y)
	);
	r2e_cordic #(.ITER(ITER), .DB(DB)) u_cz (
		.clk(clk), .en(en), .in_y(sqi_s[SQ].az_y), .in_x(sqi_s[SQ].az_x),
		.z(cz_z), .zero(zr_z)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			gen_s[0] <= sqi_s[SQ].gen;
			neg_s[0] <= sqi_s[SQ].neg;
			for (int j = 1; j <= ITER; j++) begin
				gen_s[j] <= gen_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	function automatic logic signed [15:0] rnd(input logic signed [ZW-1:0] a);
		logic signed [ZW+1:0] t;
		t = (((ZW+2)'(a) + RHALF) >>> SHR) <<< SHL;
		if (t > 32767) begin
			return 16'sh7fff;
		end else if (t < -32768) begin
			return 16'sh8000;
		end
		return t[15:0];
	endfunction

	always_comb begin
		ax = zr_x ? '0 : cz_x;
		if (!gen_s[ITER] && neg_s[ITER]) begin
			ax = -ax;
		end
		if (gen_s[ITER]) begin
			ay = zr_y ? '0 : cz_y;
			az = zr_z ? '0 : cz_z;
		end else begin
			ay = neg_s[ITER] ? -HALF_Z : HALF_Z;
			az = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_x_q <= rnd(ax);
			ang_y_q <= rnd(ay);
			ang_z_q <= rnd(az);
			uniq_q  <= gen_s[ITER];
		end
	end

	assign empty      = !vld_s[L-1];
	assign angle_x    = ang_x_q;
	assign angle_y    = ang_y_q;
	assign angle_z    = ang_z_q;
	assign unique_res = uniq_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !unique_res) |-> (angle_z == 16'sd0))
		else $error("gimbal lock beat with nonzero angle_z");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |=> vld_s[0])
		else $error("popped item lost at back entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[L-1] && !pop) |=> (vld_s[L-1] && $stable(uniq_q)))
		else $error("held result dropped or changed");

endmodule
`default_nettype wire

// File: design/rotation_matrix_to_euler.sv
`default_nettype none
// Rotation matrix to XYZ Euler angles. Push seven Q2.14 matrix elements while full is low; the
// angles come back as Q3.13 radians on a queue-style result port (empty/pop) in push order.
// A new matrix is taken every cycle while full is low. Between push and result lie the front's
// input register, the write into the four-entry queue, the square root's input register and its
// 23 stages for cos(y), CORDIC_ITERATIONS + 1 CORDIC stages and the rounding register. The back
// end stalls as a whole while a result waits unpopped; the queue lets the front keep taking
// matrices meanwhile. unique_res is low in gimbal lock (|right_z| >= 1), where angle_y is +-pi/2
// and angle_z is zero. DATA_BITS sets the fraction bits of the angle accumulator,
// CORDIC_ITERATIONS (at most 24) the number of CORDIC steps.
module rotation_matrix_to_euler #(
	parameter int CORDIC_ITERATIONS = r2e_pkg::CORDIC_ITERATIONS,
	parameter int DATA_BITS         = r2e_pkg::DATA_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input queue side
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] right_x,
	input  wire logic signed [15:0] right_y,
	input  wire logic signed [15:0] right_z,
	input  wire logic signed [15:0] up_z,
	input  wire logic signed [15:0] front_x,
	input  wire logic signed [15:0] front_y,
	input  wire logic signed [15:0] front_z,
	// result queue side
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [15:0]      angle_x,
	output logic signed [15:0]      angle_y,
	output logic signed [15:0]      angle_z,
	output logic                    unique_res
);
	// front to queue
	logic           f_push;
	logic           f_full;
	r2e_pkg::item_t f_item;
	// queue to back
	logic           b_pop;
	logic           b_empty;
	r2e_pkg::item_t b_item;

	// classify the matrix, build atan2 operands and 1 - s*s
	r2e_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.right_x(right_x), .right_y(right_y), .right_z(right_z), .up_z(up_z),
		.front_x(front_x), .front_y(front_y), .front_z(front_z),
		.fifo_full(f_full), .fifo_push(f_push), .fifo_item(f_item)
	);

	// short decoupling queue
	r2e_fifo #(.DEPTH(r2e_pkg::FIFO_DEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(f_push), .din(f_item), .full(f_full),
		.pop(b_pop), .dout(b_item), .empty(b_empty)
	);

	// square root, three CORDIC pipes, rounding and the result register
	r2e_back #(.ITER(CORDIC_ITERATIONS), .DB(DATA_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_empty(b_empty), .in_item(b_item), .in_pop(b_pop),
		.empty(empty), .pop(pop), .angle_x(angle_x), .angle_y(angle_y),
		.angle_z(angle_z), .unique_res(unique_res)
	);

endmodule
`default_nettype wire
